### rtl/bpi_pkg.sv
// Shared constants and types for the block padding inserter.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package bpi_pkg;

    localparam int MAX_BLOCK_BYTES_DEF = 64;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING_MODE = 1'd1;

    localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RESET = 7'd16;
    localparam logic [MODE_W-1:0] PADDING_MODE_RESET = 3'd2;

    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ZEROS = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PKCS  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_W3C   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ONEZ  = 3'd4;

    localparam logic [BYTE_W-1:0] ONE_ZERO_MARK = 8'h80;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic pad_step;
        logic reduce_start;
        logic reduce_step;
        logic cfg_write;
    } bpi_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic pos_over;
        logic pad_more;
        logic pad_last;
        logic reduce_last;
    } bpi_sts_t;

endpackage

### rtl/bpi_ctrl.sv
// Controller state machine of the block padding inserter.
// Depends on bpi_pkg for the command and status types.
`timescale 1ns / 1ps

module bpi_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  bpi_pkg::bpi_sts_t sts,
    output bpi_pkg::bpi_cmd_t cmd
);
    import bpi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_PAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        in_stall         = 1'b1;
        cfg_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cfg_ready     = 1'b1;
                cmd.cfg_write = cfg_valid;
                // A position not below a shortened block length is folded back first.
                if (sts.pos_over)
                begin
                    cmd.reduce_start = 1'b1;
                    state_next       = S_REDUCE;
                end
                else
                begin
                    in_stall = !sts.out_free;
                    if (in_valid && sts.out_free)
                    begin
                        cmd.accept = 1'b1;
                        if (sts.pad_more)
                        begin
                            state_next = S_PAD;
                        end
                    end
                end
            end
            S_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (sts.reduce_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PAD:
            begin
                if (sts.out_free)
                begin
                    cmd.pad_step = 1'b1;
                    if (sts.pad_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/bpi_datapath.sv
// Datapath of the block padding inserter: configuration, block position,
// remainder unit, padding counter and output register. Depends on bpi_pkg.
`timescale 1ns / 1ps

module bpi_datapath
#(
    parameter int MAX_BLOCK_BYTES = bpi_pkg::MAX_BLOCK_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  bpi_pkg::bpi_cmd_t              cmd,
    output bpi_pkg::bpi_sts_t              sts,
    input  logic [bpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpi_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic                           end_of_message,
    input  logic [bpi_pkg::BYTE_W-1:0]     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bpi_pkg::BYTE_W-1:0]     out_byte,
    output logic                           byte_present,
    output logic                           is_padding,
    output logic                           message_done
);
    import bpi_pkg::*;

    localparam int POS_W  = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
    localparam int CMP_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
    localparam int STEP_W = (POS_W > 1) ? $clog2(POS_W) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(POS_W - 1);

    logic [LEN_W-1:0]  block_length_reg;
    logic [MODE_W-1:0] padding_mode_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  remain_reg;
    logic [BYTE_W-1:0] pad_byte_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [POS_W-1:0]  shift_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              byte_present_reg;
    logic              is_padding_reg;
    logic              message_done_reg;

    logic [LEN_W-1:0]  eff_len;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  pos_inc;
    logic [LEN_W-1:0]  fill;
    logic [LEN_W-1:0]  to_edge;
    logic [LEN_W-1:0]  count;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] later_byte;
    logic [LEN_W:0]    trial;
    logic [LEN_W-1:0]  rem_new;
    logic              out_free;

    // Zero block length acts as one; lengths above the maximum saturate.
    always_comb
    begin
        if (block_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(block_length_reg) > MAX_BLOCK_BYTES)
        begin
            eff_len = LEN_W'(MAX_BLOCK_BYTES);
        end
        else
        begin
            eff_len = block_length_reg;
        end
    end

    assign len_ext = CMP_W'(eff_len);
    assign pos_ext = CMP_W'(pos_reg);
    assign pos_inc = pos_ext + CMP_W'(1);

    // The position is below the block length whenever an item is taken.
    assign fill    = eff_len - LEN_W'(pos_reg);
    assign to_edge = (pos_reg == '0) ? '0 : fill;

    always_comb
    begin
        first_byte = '0;
        later_byte = '0;
        case (padding_mode_reg)
            MODE_NONE:
            begin
                count = '0;
            end
            MODE_ZEROS:
            begin
                count = to_edge;
            end
            MODE_PKCS:
            begin
                count      = fill;
                first_byte = BYTE_W'(fill);
                later_byte = BYTE_W'(fill);
            end
            MODE_W3C:
            begin
                count      = to_edge;
                first_byte = BYTE_W'(to_edge);
                later_byte = BYTE_W'(to_edge);
            end
            default:
            begin
                count      = fill;
                first_byte = ONE_ZERO_MARK;
            end
        endcase
    end

    // One step of the restoring remainder.
    assign trial   = {rem_reg, shift_reg[POS_W-1]};
    assign rem_new = (trial >= {1'b0, eff_len}) ? LEN_W'(trial - {1'b0, eff_len})
                                                 : LEN_W'(trial);

    assign out_free = !out_valid_reg || !out_stall;

    assign sts.out_free    = out_free;
    assign sts.pos_over    = pos_ext >= len_ext;
    assign sts.pad_more    = end_of_message && (count > LEN_W'(1));
    assign sts.pad_last    = remain_reg == LEN_W'(1);
    assign sts.reduce_last = step_reg == STEP_LAST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLOCK_LENGTH_RESET;
            padding_mode_reg <= PADDING_MODE_RESET;
            pos_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                unique case (cfg_index)
                    REG_BLOCK_LENGTH: block_length_reg <= cfg_data;
                    REG_PADDING_MODE: padding_mode_reg <= cfg_data[MODE_W-1:0];
                    default:          ;
                endcase
            end

            if (cmd.accept)
            begin
                if (end_of_message)
                begin
                    pos_reg <= '0;
                end
                else if (pos_inc == len_ext)
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= POS_W'(pos_inc);
                end
            end
            else if (cmd.reduce_step && sts.reduce_last)
            begin
                pos_reg <= POS_W'(rem_new);
            end

            if (cmd.accept || cmd.pad_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.reduce_start)
        begin
            rem_reg   <= '0;
            shift_reg <= pos_reg;
            step_reg  <= '0;
        end
        else if (cmd.reduce_step)
        begin
            rem_reg   <= rem_new;
            shift_reg <= shift_reg << 1;
            step_reg  <= step_reg + STEP_W'(1);
        end

        if (cmd.accept)
        begin
            if (!end_of_message)
            begin
                out_byte_reg     <= data_byte;
                byte_present_reg <= 1'b1;
                is_padding_reg   <= 1'b0;
                message_done_reg <= 1'b0;
            end
            else if (count == '0)
            begin
                out_byte_reg     <= '0;
                byte_present_reg <= 1'b0;
                is_padding_reg   <= 1'b0;
                message_done_reg <= 1'b1;
            end
            else
            begin
                out_byte_reg     <= first_byte;
                byte_present_reg <= 1'b1;
                is_padding_reg   <= 1'b1;
                message_done_reg <= count == LEN_W'(1);
            end
            remain_reg   <= count - LEN_W'(1);
            pad_byte_reg <= later_byte;
        end
        else if (cmd.pad_step)
        begin
            out_byte_reg     <= pad_byte_reg;
            byte_present_reg <= 1'b1;
            is_padding_reg   <= 1'b1;
            message_done_reg <= remain_reg == LEN_W'(1);
            remain_reg       <= remain_reg - LEN_W'(1);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_present = byte_present_reg;
    assign is_padding   = is_padding_reg;
    assign message_done = message_done_reg;

endmodule

### rtl/block_padding_inserter.sv
// Block padding inserter: message bytes pass one per cycle; an end-of-message request emits
// padding bytes one per cycle, up to the block length (count = mode result), while the output
// is not stalled. An accepted request's first result is in the output register in the cycle after.
// An end request holds off the next request until its last padding byte has been issued. After a
// block length change that leaves the position not below the new length, a start step and a restoring
// remainder fold the position back and stall the next request. Reset: async active low, 16 / pkcs.
`timescale 1ns / 1ps

module block_padding_inserter
#(
    parameter int MAX_BLOCK_BYTES = bpi_pkg::MAX_BLOCK_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           end_of_message,
    input  logic [bpi_pkg::BYTE_W-1:0]     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bpi_pkg::BYTE_W-1:0]     out_byte,
    output logic                           byte_present,
    output logic                           is_padding,
    output logic                           message_done,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpi_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import bpi_pkg::*;

    bpi_cmd_t cmd;
    bpi_sts_t sts;

    bpi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpi_datapath #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .end_of_message (end_of_message),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_present   (byte_present),
        .is_padding     (is_padding),
        .message_done   (message_done)
    );

endmodule

### rtl/bpi_checker.sv
// Port-level checks for the block padding inserter, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module bpi_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       end_of_message,
    input logic [7:0] data_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_present,
    input logic       is_padding,
    input logic       message_done,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       cfg_index,
    input logic [6:0] cfg_data
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A data request shows up as the next result, unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !end_of_message |=>
            out_valid && byte_present && !is_padding && !message_done
            && out_byte == $past(data_byte))
        else $error("data byte not passed through");

    // A bare end marker carries nothing else.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_present |-> message_done && !is_padding && out_byte == 8'h00)
        else $error("malformed end marker");

    // A padding byte is always a present byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_padding |-> byte_present)
        else $error("padding without byte");

endmodule

bind block_padding_inserter bpi_checker u_bpi_checker (.*);

### test/block_padding_inserter_tb.sv
// Self-checking testbench for the block padding inserter: directed padding cases, then random
// messages under varying sender and receiver idling. Depends on bpi_pkg and the RTL top level.
`timescale 1ns / 1ps

module block_padding_inserter_tb;

    import bpi_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] octet;
        logic              present;
        logic              pad;
        logic              done;
    } padded_byte_t;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic                 end_of_message = 1'b0;
    logic [BYTE_W-1:0]    data_byte      = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 byte_present;
    logic                 is_padding;
    logic                 message_done;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_DAT_W-1:0] cfg_data       = '0;

    // Shadow copy of the block's registers and position.
    logic [LEN_W-1:0]  block_length_reg = BLOCK_LENGTH_RESET;
    logic [MODE_W-1:0] padding_mode_reg = PADDING_MODE_RESET;
    int unsigned       block_position   = 0;

    padded_byte_t expected_bytes[$];
    int failures       = 0;
    int requests_sent  = 0;
    int send_idle_pct  = 35;
    int recv_stall_pct = 45;

    block_padding_inserter dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .end_of_message (end_of_message),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_present   (byte_present),
        .is_padding     (is_padding),
        .message_done   (message_done),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int unsigned effective_block_bytes();
        int unsigned bytes;
        bytes = block_length_reg;
        if (bytes == 0)
        begin
            bytes = 1;
        end
        if (bytes > MAX_BLOCK_BYTES_DEF)
        begin
            bytes = MAX_BLOCK_BYTES_DEF;
        end
        return bytes;
    endfunction

    // Works out the bytes that one accepted request produces and updates the position.
    function automatic void predict_padding(input logic eom, input logic [BYTE_W-1:0] data);
        int unsigned  len;
        int unsigned  offset;
        int unsigned  fill;
        int unsigned  to_edge;
        int unsigned  count;
        padded_byte_t res;
        len     = effective_block_bytes();
        offset  = block_position % len;
        fill    = len - offset;
        to_edge = fill % len;
        if (!eom)
        begin
            res = '{data, 1'b1, 1'b0, 1'b0};
            expected_bytes.push_back(res);
            offset++;
            block_position = (offset >= len) ? 0 : offset;
            return;
        end
        block_position = 0;
        case (padding_mode_reg)
            MODE_NONE:  count = 0;
            MODE_ZEROS: count = to_edge;
            MODE_PKCS:  count = fill;
            MODE_W3C:   count = to_edge;
            default:    count = fill;
        endcase
        if (count == 0)
        begin
            res = '{8'h00, 1'b0, 1'b0, 1'b1};
            expected_bytes.push_back(res);
            return;
        end
        for (int unsigned i = 0; i < count; i++)
        begin
            if (padding_mode_reg == MODE_ZEROS)
            begin
                res.octet = 8'h00;
            end
            else if (padding_mode_reg == MODE_PKCS || padding_mode_reg == MODE_W3C)
            begin
                res.octet = count[BYTE_W-1:0];
            end
            else
            begin
                res.octet = (i == 0) ? ONE_ZERO_MARK : 8'h00;
            end
            res.present = 1'b1;
            res.pad     = 1'b1;
            res.done    = (i + 1 == count);
            expected_bytes.push_back(res);
        end
    endfunction

    function automatic logic [CFG_DAT_W-1:0] random_block_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_DAT_W'($urandom_range(65, 127));
            2:       return CFG_DAT_W'(MAX_BLOCK_BYTES_DEF);
            default: return CFG_DAT_W'($urandom_range(1, 16));
        endcase
    endfunction

    // Valid is left high after acceptance; the next call decides whether it stays high.
    task automatic send_request(input logic eom, input logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        end_of_message <= eom;
        data_byte      <= data;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_padding(eom, data);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(input int length);
        for (int k = 0; k < length; k++)
        begin
            send_request(1'b0, BYTE_W'($urandom_range(0, 255)));
        end
        send_request(1'b1, BYTE_W'($urandom_range(0, 255)));
    endtask

    // Registers change only once every outstanding byte has come out.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DAT_W-1:0] value);
        while (expected_bytes.size() != 0)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (index == REG_BLOCK_LENGTH)
        begin
            block_length_reg = value[LEN_W-1:0];
        end
        else
        begin
            padding_mode_reg = value[MODE_W-1:0];
        end
        @(negedge clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] mode);
        write_register(REG_PADDING_MODE, CFG_DAT_W'(mode));
    endtask

    task automatic test_default_pkcs();
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b1, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_none_and_zeros();
        set_mode(MODE_NONE);
        send_request(1'b0, 8'hA5);
        send_request(1'b1, 8'hFF);
        set_mode(MODE_ZEROS);
        write_register(REG_BLOCK_LENGTH, 7'd5);
        send_message(2);
        // A one-byte block is always aligned, so zero padding yields only the end marker.
        write_register(REG_BLOCK_LENGTH, 7'd1);
        send_message(0);
    endtask

    task automatic test_length_extremes();
        set_mode(MODE_PKCS);
        write_register(REG_BLOCK_LENGTH, 7'd0);
        send_message(0);
        set_mode(MODE_ONEZ);
        write_register(REG_BLOCK_LENGTH, 7'd127);
        send_message(0);
        set_mode(3'(MODE_ONEZ + 3));
        write_register(REG_BLOCK_LENGTH, CFG_DAT_W'(MAX_BLOCK_BYTES_DEF));
        send_message(1);
    endtask

    task automatic test_w3c();
        set_mode(MODE_W3C);
        write_register(REG_BLOCK_LENGTH, 7'd4);
        send_message(3);
        send_message(0);
    endtask

    task automatic test_length_change();
        set_mode(MODE_PKCS);
        write_register(REG_BLOCK_LENGTH, 7'd8);
        for (int k = 0; k < 6; k++)
        begin
            send_request(1'b0, BYTE_W'($urandom_range(0, 255)));
        end
        // The stored position of six wraps to two in a four-byte block.
        write_register(REG_BLOCK_LENGTH, 7'd4);
        send_request(1'b1, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int budget);
        int first;
        int msg_len;
        int split;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first          = requests_sent;
        while (requests_sent - first < budget)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_register(REG_BLOCK_LENGTH, random_block_length());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                set_mode(MODE_W'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 4) == 0)
            begin
                msg_len = 0;
            end
            else
            begin
                msg_len = $urandom_range(1, 2 * effective_block_bytes());
            end
            split = ($urandom_range(0, 7) == 0) ? $urandom_range(0, msg_len) : -1;
            for (int k = 0; k < msg_len; k++)
            begin
                if (k == split)
                begin
                    write_register(REG_BLOCK_LENGTH, random_block_length());
                end
                send_request(1'b0, BYTE_W'($urandom_range(0, 255)));
            end
            send_request(1'b1, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic finish_traffic();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        padded_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %0h byte_present %0b", out_byte,
                       byte_present);
                failures++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.octet)
                begin
                    $error("out_byte: expected %0h, actual %0h", want.octet, out_byte);
                    failures++;
                end
                if (byte_present !== want.present)
                begin
                    $error("byte_present: expected %0b, actual %0b", want.present,
                           byte_present);
                    failures++;
                end
                if (is_padding !== want.pad)
                begin
                    $error("is_padding: expected %0b, actual %0b", want.pad, is_padding);
                    failures++;
                end
                if (message_done !== want.done)
                begin
                    $error("message_done: expected %0b, actual %0b", want.done,
                           message_done);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_pkcs();
        test_none_and_zeros();
        test_length_extremes();
        test_w3c();
        test_length_change();
        test_random_traffic(35, 45, 120);
        test_random_traffic(45, 35, 120);
        test_random_traffic(0, 0, 120);
        finish_traffic();
        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
